/* hw/rtl/plm_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plm_pkg: shared codes and types of the positional list
// request kinds, status codes and the per-cell control word
// ---------------------------------------------------------------------------
package plm_pkg;

   localparam int KindWidth   = 2;
   localparam int PosWidth    = 7;
   localparam int DataWidth   = 32;
   localparam int StatusWidth = 2;
   localparam int CountWidth  = 8;

   localparam logic [KindWidth-1:0] KIND_INSERT = 2'd0;
   localparam logic [KindWidth-1:0] KIND_DELETE = 2'd1;
   localparam logic [KindWidth-1:0] KIND_READ   = 2'd2;

   localparam logic [StatusWidth-1:0] ST_DONE  = 2'd0;
   localparam logic [StatusWidth-1:0] ST_FULL  = 2'd1;
   localparam logic [StatusWidth-1:0] ST_RANGE = 2'd2;

   // control word that the top hands to each cell every cycle
   typedef struct packed {
      logic load_item;   // take the inserted item
      logic take_left;   // shift up: take the lower neighbor
      logic take_right;  // shift down: take the upper neighbor
      logic tap;         // drive own data onto the read bus
   } cell_ctrl_type;

endpackage

/* hw/rtl/plm_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plm request and response channels
// valid/ready channels carrying the list request and its response
// ---------------------------------------------------------------------------
interface plm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [plm_pkg::KindWidth-1:0]        kind;
   logic [plm_pkg::PosWidth-1:0]         position;
   logic signed [plm_pkg::DataWidth-1:0] item;

   modport source (output valid, kind, position, item, input ready);
   modport sink   (input valid, kind, position, item, output ready);
endinterface

interface plm_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [plm_pkg::StatusWidth-1:0]      status;
   logic signed [plm_pkg::DataWidth-1:0] value;
   logic [plm_pkg::CountWidth-1:0]       count;
   logic                                 empty_res;
   logic                                 full_res;

   modport source (output valid, status, value, count, empty_res, full_res, input ready);
   modport sink   (input valid, status, value, count, empty_res, full_res, output ready);
endinterface

/* hw/rtl/plm_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plm_cell: one list slot
// holds one element, loads the item or a neighbor, taps onto the read bus
// ---------------------------------------------------------------------------
module plm_cell (
   input  logic                                 clock,
   input  plm_pkg::cell_ctrl_type               ctrl,
   input  logic signed [plm_pkg::DataWidth-1:0] item,
   input  logic signed [plm_pkg::DataWidth-1:0] left_data,
   input  logic signed [plm_pkg::DataWidth-1:0] right_data,
   output logic signed [plm_pkg::DataWidth-1:0] data,
   output logic signed [plm_pkg::DataWidth-1:0] tap_data
);

   logic signed [plm_pkg::DataWidth-1:0] data_ff;
   logic signed [plm_pkg::DataWidth-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load_item) begin
         data_in = item;
      end else if (ctrl.take_left) begin
         data_in = left_data;
      end else if (ctrl.take_right) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign tap_data = ctrl.tap ? data_ff : '0;

endmodule

/* hw/rtl/positional_list_insert_delete.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// positional_list_insert_delete: packed list with insert/delete at position
// a row of cells that all shift in the same cycle, plus an output register
// ---------------------------------------------------------------------------
// the response is registered in the output register in the cycle after its request is accepted
// throughput: one request per cycle while the response is taken; every cell shifts in the accept cycle
// the read bus is an or of every cell's tap, which sets the cycle time
// reset clears the length and the response valid; cell contents are undefined
// until written, and only cells below the length are ever read
module positional_list_insert_delete #(
   parameter int CAPACITY = 128
) (
   input  logic        clock,
   input  logic        reset,
   plm_req_if.sink     req_chan,
   plm_rsp_if.source   rsp_chan
);

   localparam int CW = $clog2(CAPACITY + 1);   // length counter width
   localparam int PW = (CW > plm_pkg::PosWidth) ? CW : plm_pkg::PosWidth;
   localparam int DW = plm_pkg::DataWidth;

   // length and response register
   logic [CW-1:0]                   used_ff, used_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [plm_pkg::StatusWidth-1:0] status_ff, status_in;
   logic signed [DW-1:0]            value_ff, value_in;
   logic [plm_pkg::CountWidth-1:0]  count_ff, count_in;
   logic                            empty_ff, empty_in;
   logic                            full_ff, full_in;

   logic            accept;
   logic [PW-1:0]   pos_ext;
   logic [PW-1:0]   used_ext;
   logic            is_full;
   logic            ins_ok;
   logic            del_ok;
   logic            rd_ok;
   logic [CW+plm_pkg::CountWidth-1:0] used_wide;

   // cell row wiring
   plm_pkg::cell_ctrl_type ctrl [CAPACITY];
   logic signed [DW-1:0]   cell_data [CAPACITY];
   logic signed [DW-1:0]   cell_tap  [CAPACITY];
   logic signed [DW-1:0]   read_bus;

   // response register frees when empty or being taken
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign pos_ext  = PW'(req_chan.position);
   assign used_ext = PW'(used_ff);
   assign is_full  = (used_ff == CW'(CAPACITY));

   // fullness is checked before the position for inserts
   assign ins_ok = accept && (req_chan.kind == plm_pkg::KIND_INSERT)
                   && !is_full && (pos_ext <= used_ext);
   assign del_ok = accept && (req_chan.kind == plm_pkg::KIND_DELETE)
                   && (pos_ext < used_ext);
   assign rd_ok  = accept && (req_chan.kind == plm_pkg::KIND_READ)
                   && (pos_ext < used_ext);

   // per-cell control: cells above the position shift up on insert,
   // cells at and above it shift down on delete
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [PW-1:0] Idx = PW'(i);
      logic signed [DW-1:0] left_d;
      logic signed [DW-1:0] right_d;

      always_comb begin
         ctrl[i].load_item  = ins_ok && (Idx == pos_ext);
         ctrl[i].take_left  = ins_ok && (Idx >  pos_ext);
         ctrl[i].take_right = del_ok && (Idx >= pos_ext);
         ctrl[i].tap        = (Idx == pos_ext);
      end

      // row ends: no neighbor, the slot keeps its own data
      if (i == 0) begin : g_first
         assign left_d = cell_data[i];
      end else begin : g_left
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_right
         assign right_d = cell_data[i+1];
      end

      plm_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[i]),
         .item       (req_chan.item),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i]),
         .tap_data   (cell_tap[i])
      );
   end

   // read bus: only the addressed cell taps, so an or collects it
   always_comb begin
      read_bus = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_bus = read_bus | cell_tap[i];
      end
   end

   // next length and response
   always_comb begin
      used_in = used_ff;
      if (ins_ok) begin
         used_in = used_ff + CW'(1);
      end else if (del_ok) begin
         used_in = used_ff - CW'(1);
      end

      status_in = plm_pkg::ST_DONE;
      case (req_chan.kind)
         plm_pkg::KIND_INSERT: begin
            if (is_full) begin
               status_in = plm_pkg::ST_FULL;
            end else if (pos_ext > used_ext) begin
               status_in = plm_pkg::ST_RANGE;
            end
         end
         plm_pkg::KIND_DELETE, plm_pkg::KIND_READ: begin
            if (pos_ext >= used_ext) begin
               status_in = plm_pkg::ST_RANGE;
            end
         end
         default: status_in = plm_pkg::ST_DONE;
      endcase

      value_in  = (del_ok || rd_ok) ? read_bus : '0;
      used_wide = {{plm_pkg::CountWidth{1'b0}}, used_in};
      count_in  = used_wide[plm_pkg::CountWidth-1:0];
      empty_in  = (used_in == '0);
      full_in   = (used_in == CW'(CAPACITY));

      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded with each accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         value_ff  <= value_in;
         count_ff  <= count_in;
         empty_ff  <= empty_in;
         full_ff   <= full_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.value     = value_ff;
   assign rsp_chan.count     = count_ff;
   assign rsp_chan.empty_res = empty_ff;
   assign rsp_chan.full_res  = full_ff;

endmodule
